[hw/rtl/ct_pkg.sv]
// ----------------------------------------------------------------------------
// Columnar transposition package
// Shared types, constants and helpers for the columnar transposition block.
// ----------------------------------------------------------------------------
package ct_pkg;

  localparam int KEY_W     = 6;
  localparam int KEY_MAX   = 32;
  localparam int RES_W     = 6;
  localparam int MAX_RESULTS = 63;
  localparam logic [7:0] PAD_CHAR = 8'h20;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_COLUMNS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECRYPT_MODE = 1'd1;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_out;
    logic       overflow;
  } out_item_t;

  // Classified item handed from the front to the back.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
    logic       keep;
  } cmd_t;

  function automatic logic [KEY_W-1:0] eff_key(input logic [KEY_W-1:0] key);
    logic [KEY_W-1:0] result;
    if (key == '0) begin
      result = KEY_W'(1);
    end else if (key > KEY_W'(KEY_MAX)) begin
      result = KEY_W'(KEY_MAX);
    end else begin
      result = key;
    end
    return result;
  endfunction

endpackage

[hw/rtl/ct_front.sv]
// ----------------------------------------------------------------------------
// Columnar transposition front end
// Accepts message bytes and marks each one as kept or dropped by buffer room.
// ----------------------------------------------------------------------------
module ct_front #(
  parameter int BUF_DEPTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  ct_pkg::in_item_t in_data,
  output logic             push_valid,
  input  logic             push_ready,
  output ct_pkg::cmd_t     push_data
);

  localparam int LEN_W = $clog2(BUF_DEPTH + 1);

  logic [LEN_W-1:0] count;
  logic             keep;

  assign keep       = count < LEN_W'(BUF_DEPTH);
  assign in_ready   = push_ready;
  assign push_valid = in_valid;

  always_comb begin
    push_data.text_byte = in_data.text_byte;
    push_data.last_byte = in_data.last_byte;
    push_data.keep      = keep;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (in_valid && push_ready) begin
      if (in_data.last_byte) begin
        count <= '0;
      end else if (keep) begin
        count <= count + LEN_W'(1);
      end
    end
  end

endmodule

[hw/rtl/ct_queue.sv]
// ----------------------------------------------------------------------------
// Columnar transposition command queue
// Two-entry queue between the front end and the run engine.
// ----------------------------------------------------------------------------
module ct_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_ready,
  input  ct_pkg::cmd_t push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output ct_pkg::cmd_t pop_data
);

  ct_pkg::cmd_t entries [2];
  logic         wptr;
  logic         rptr;
  logic [1:0]   count;
  logic         do_push;
  logic         do_pop;

  assign push_ready = count != 2'd2;
  assign pop_valid  = count != 2'd0;
  assign pop_data   = entries[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wptr <= ~wptr;
      end
      if (do_pop) begin
        rptr <= ~rptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

[hw/rtl/ct_back.sv]
// ----------------------------------------------------------------------------
// Columnar transposition run engine
// Buffers the message, divides length by key, then streams the permuted run.
// ----------------------------------------------------------------------------
module ct_back #(
  parameter int BUF_DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cmd_valid,
  output logic                     cmd_ready,
  input  ct_pkg::cmd_t             cmd,
  input  logic [ct_pkg::KEY_W-1:0] key_columns,
  input  logic                     decrypt_mode,
  output logic                     out_valid,
  input  logic                     out_ready,
  output ct_pkg::out_item_t        out_data
);

  localparam int ADDR_W = $clog2(BUF_DEPTH);
  localparam int LEN_W  = $clog2(BUF_DEPTH + 1);
  localparam int POS_W  = $clog2(BUF_DEPTH + ct_pkg::KEY_MAX);
  localparam int STEP_W = $clog2(LEN_W + 1);
  localparam int KEY_W  = ct_pkg::KEY_W;
  localparam int RES_W  = ct_pkg::RES_W;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_DIV,
    ST_SETUP,
    ST_RUN
  } state_t;

  logic [7:0] mem [BUF_DEPTH];

  state_t             state;
  logic [LEN_W-1:0]   fill_count;
  logic               overflow_seen;
  logic [LEN_W-1:0]   len;
  logic [LEN_W-1:0]   div_num;
  logic [KEY_W-1:0]   div_rem;
  logic [LEN_W-1:0]   div_quo;
  logic [STEP_W-1:0]  div_step;
  logic [LEN_W-1:0]   rows;
  logic [RES_W-1:0]   total;
  logic [RES_W-1:0]   k;
  logic [POS_W-1:0]   p;
  logic [POS_W-1:0]   base;
  logic [KEY_W-1:0]   c;
  logic [LEN_W-1:0]   r;

  logic               rd_valid;
  logic [7:0]         rd_byte;
  logic               rd_pad;
  logic               rd_last;
  logic               rd_ovf;

  logic [KEY_W-1:0]   keff;
  logic               pop;
  logic               issue;
  logic               rd_move;
  logic [POS_W-1:0]   pos;
  logic               pos_pad;
  logic               is_last;
  logic [KEY_W-1:0]   div_trial;
  logic               div_ge;
  logic [POS_W-1:0]   padded;
  logic [POS_W-1:0]   total_full;
  logic [LEN_W-1:0]   load_len;

  assign keff      = ct_pkg::eff_key(key_columns);
  assign cmd_ready = state == ST_LOAD;
  assign pop       = cmd_valid && cmd_ready;
  assign rd_move   = rd_valid && (!out_valid || out_ready);
  assign issue     = (state == ST_RUN) && (!rd_valid || rd_move);
  assign pos       = decrypt_mode ? (base + POS_W'(r)) : p;
  assign pos_pad   = pos >= POS_W'(len);
  assign is_last   = ({1'b0, k} + (RES_W + 1)'(1)) == {1'b0, total};
  assign load_len  = fill_count + LEN_W'(cmd.keep);

  assign div_trial = {div_rem[KEY_W-2:0], div_num[LEN_W-1]};
  assign div_ge    = div_trial >= keff;

  assign padded     = (div_rem != '0) ? (POS_W'(len) + POS_W'(keff - div_rem)) : POS_W'(len);
  assign total_full = decrypt_mode ? POS_W'(len) : padded;

  always_ff @(posedge clk) begin
    if (pop && cmd.keep) begin
      mem[fill_count[ADDR_W-1:0]] <= cmd.text_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_byte <= mem[pos[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      fill_count    <= '0;
      overflow_seen <= 1'b0;
      rd_valid      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (pop) begin
            if (cmd.keep) begin
              fill_count <= fill_count + LEN_W'(1);
            end else begin
              overflow_seen <= 1'b1;
            end
            if (cmd.last_byte) begin
              len      <= load_len;
              div_num  <= load_len;
              div_rem  <= '0;
              div_quo  <= '0;
              div_step <= '0;
              state    <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          div_num <= {div_num[LEN_W-2:0], 1'b0};
          div_quo <= {div_quo[LEN_W-2:0], div_ge};
          div_rem <= div_ge ? (div_trial - keff) : div_trial;
          div_step <= div_step + STEP_W'(1);
          if (div_step == STEP_W'(LEN_W - 1)) begin
            state <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          rows  <= div_quo + LEN_W'(div_rem != '0);
          total <= (total_full > POS_W'(ct_pkg::MAX_RESULTS)) ?
                   RES_W'(ct_pkg::MAX_RESULTS) : total_full[RES_W-1:0];
          k     <= '0;
          p     <= '0;
          base  <= '0;
          c     <= '0;
          r     <= '0;
          state <= ST_RUN;
        end
        ST_RUN: begin
          if (issue) begin
            k <= k + RES_W'(1);
            if (decrypt_mode) begin
              if (c == keff - KEY_W'(1)) begin
                c    <= '0;
                base <= '0;
                r    <= r + LEN_W'(1);
              end else begin
                c    <= c + KEY_W'(1);
                base <= base + POS_W'(div_quo) + POS_W'(c < div_rem);
              end
            end else begin
              if (r == rows - LEN_W'(1)) begin
                r <= '0;
                c <= c + KEY_W'(1);
                p <= POS_W'(c) + POS_W'(1);
              end else begin
                r <= r + LEN_W'(1);
                p <= p + POS_W'(keff);
              end
            end
            if (is_last) begin
              fill_count    <= '0;
              overflow_seen <= 1'b0;
              state         <= ST_LOAD;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase

      if (issue) begin
        rd_valid <= 1'b1;
        rd_pad   <= pos_pad;
        rd_last  <= is_last;
        rd_ovf   <= overflow_seen;
      end else if (rd_move) begin
        rd_valid <= 1'b0;
      end

      if (rd_move) begin
        out_valid         <= 1'b1;
        out_data.out_byte <= rd_pad ? ct_pkg::PAD_CHAR : rd_byte;
        out_data.last_out <= rd_last;
        out_data.overflow <= rd_ovf;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/columnar_transposition_top.sv]
// ----------------------------------------------------------------------------
// Columnar transposition top level
// Buffers one message and emits it permuted by a columnar transposition key.
// ----------------------------------------------------------------------------
// Loading takes one byte per cycle while the engine loads; a two-entry queue parts input from
// the engine. After the final byte, a bit-serial length-by-key division, the run setup and
// the registered buffer read come before out_valid rises.
// The run then streams one result per cycle while the output is taken.
// Reset clears control state and sets key_columns to 1 and decrypt_mode to 0.
// The message buffer is not cleared; only entries written for the current message are read.
module columnar_transposition_top #(
  parameter int BUF_DEPTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ct_pkg::in_item_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ct_pkg::out_item_t             out_data,
  input  logic                          cfg_wr_en,
  input  logic [ct_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ct_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic [ct_pkg::KEY_W-1:0] key_columns;
  logic                     decrypt_mode;

  logic         push_valid;
  logic         push_ready;
  ct_pkg::cmd_t push_data;
  logic         pop_valid;
  logic         pop_ready;
  ct_pkg::cmd_t pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_columns  <= ct_pkg::KEY_W'(1);
      decrypt_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        ct_pkg::REG_KEY_COLUMNS:  key_columns  <= cfg_wdata[ct_pkg::KEY_W-1:0];
        ct_pkg::REG_DECRYPT_MODE: decrypt_mode <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  ct_front #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  ct_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  ct_back #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (pop_valid),
    .cmd_ready    (pop_ready),
    .cmd          (pop_data),
    .key_columns  (key_columns),
    .decrypt_mode (decrypt_mode),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

endmodule
